>>> rtl/ipv4cs_pkg.sv
// ----------------------------------------------------------------------------
// ipv4cs_pkg: shared types and constants of the IPv4 checksum fill unit
// Protocol numbers, status codes, frame offsets and ones'-complement helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4cs_pkg;

  localparam int unsigned POS_W = 17;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [POS_W:0]   pos_ext_t;

  typedef enum logic [2:0] {
    STATUS_SKIP   = 3'd0,
    STATUS_HEADER = 3'd1,
    STATUS_ICMP   = 3'd2,
    STATUS_TCP    = 3'd3,
    STATUS_UDP    = 3'd4
  } fill_status_e;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [7:0] ETYPE_HI = 8'h08;
  localparam logic [7:0] ETYPE_LO = 8'h00;

  localparam pos_t POS_ETYPE_HI = pos_t'(12);
  localparam pos_t POS_ETYPE_LO = pos_t'(13);
  localparam pos_t POS_VER_IHL  = pos_t'(14);
  localparam pos_t POS_FIRST_HW = pos_t'(15);
  localparam pos_t POS_TOT_HI   = pos_t'(16);
  localparam pos_t POS_TOT_LO   = pos_t'(17);
  localparam pos_t POS_PROTO    = pos_t'(23);
  localparam pos_t POS_HCSUM    = pos_t'(24);
  localparam pos_t POS_SRC_ADDR = pos_t'(26);
  localparam pos_t POS_DST_LAST = pos_t'(32);
  localparam pos_t POS_MAX      = {POS_W{1'b1}};

  localparam logic [6:0] ETH_HDR_LEN = 7'd14;
  localparam logic [6:0] MIN_IHL     = 7'd20;
  localparam logic [6:0] MIN_FRAME   = 7'd34;
  localparam logic [15:0] MIN_ICMP_UDP = 16'd8;
  localparam logic [15:0] MIN_TCP      = 16'd20;

  localparam logic [4:0] OFF_ICMP = 5'd2;
  localparam logic [4:0] OFF_TCP  = 5'd16;
  localparam logic [4:0] OFF_UDP  = 5'd6;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [4:0] field_offset(input logic [7:0] proto);
    logic [4:0] off;
    case (proto)
      PROTO_ICMP: off = OFF_ICMP;
      PROTO_TCP:  off = OFF_TCP;
      PROTO_UDP:  off = OFF_UDP;
      default:    off = 5'd0;
    endcase
    return off;
  endfunction

  function automatic logic has_field(input logic [7:0] proto);
    return (proto == PROTO_ICMP) || (proto == PROTO_TCP) || (proto == PROTO_UDP);
  endfunction

endpackage

`default_nettype wire

>>> rtl/ipv4_checksum_fill_unit.sv
// ----------------------------------------------------------------------------
// ipv4_checksum_fill_unit: IPv4 / ICMP / TCP / UDP transmit checksum engine
// Sums an Ethernet frame byte by byte and reports the checksums on the last word.
// ----------------------------------------------------------------------------
// The unit takes one frame byte per clock cycle, back to back, with no gap
// between frames. Each accepted word passes an input register and then
// updates the running ones'-complement sums, one 16-bit adder per sum. The
// word that carries tlast produces one result word: once it leaves the
// input register, the frame totals are captured in a snapshot register, and the
// status, the final folds and the field offset are computed into the output
// register. No other word produces a result. The unit keeps taking bytes
// while results wait on the output side; it stalls only when a frame end
// reaches the input register while both the snapshot and the output register
// still hold results.
`default_nettype none

module ipv4_checksum_fill_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] frame_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o    // [2:0] fill_status, [18:3] header_checksum,
                                             // [34:19] transport_checksum,
                                             // [41:35] transport_offset, [47:42] zero
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Frame state.
  ipv4cs_pkg::pos_t pos_q, pos_d;
  logic [15:0] hsum_q, hsum_d, hsum_n;
  logic [15:0] psum_q, psum_d, psum_n;
  logic [6:0]  ihl_q, ihl_d, ihl_n;
  logic [15:0] tot_q, tot_d, tot_n;
  logic [7:0]  proto_q, proto_d, proto_n;
  logic [15:0] udp_old_q, udp_old_d, udp_old_n;
  logic [7:0]  pend_q, pend_d, pend_n;
  logic        ipv4_q, ipv4_d, ipv4_n;

  // Snapshot of the finished frame.
  logic                 snap_valid_q;
  ipv4cs_pkg::pos_ext_t snap_len_q;
  logic                 snap_ipv4_q;
  logic [6:0]           snap_ihl_q;
  logic [15:0]          snap_tot_q;
  logic [7:0]           snap_proto_q;
  logic [15:0]          snap_hsum_q;
  logic [15:0]          snap_psum_q;
  logic [15:0]          snap_udp_old_q;

  // Output register.
  logic        out_valid_q;
  logic [47:0] out_data_q, out_data_d;

  logic out_ready, snap_ready, consume, in_ready;

  assign out_ready  = !out_valid_q || m_axis_tready_i;
  assign snap_ready = !snap_valid_q || out_ready;
  assign consume    = in_valid_q && (!in_last_q || snap_ready);
  assign in_ready   = !in_valid_q || consume;

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Byte processing.
  ipv4cs_pkg::pos_t     hp;
  ipv4cs_pkg::pos_ext_t pos_p1, tend;
  logic [6:0]  tstart, cpos;
  logic [15:0] word, psum_add;
  logic        ihl_ok, pseudo, in_transport, even_tail, cpos_hit, psum_en;

  always_comb begin
    hp       = pos_q - ipv4cs_pkg::pos_t'(1);
    pos_p1   = ipv4cs_pkg::pos_ext_t'(pos_q) + ipv4cs_pkg::pos_ext_t'(1);
    tend     = ipv4cs_pkg::pos_ext_t'(tot_q) + ipv4cs_pkg::pos_ext_t'(ipv4cs_pkg::ETH_HDR_LEN);
    tstart   = ipv4cs_pkg::ETH_HDR_LEN + ihl_q;
    cpos     = tstart + {2'd0, ipv4cs_pkg::field_offset(proto_q)};
    word     = {pend_q, in_byte_q};
    ihl_ok   = ihl_q >= ipv4cs_pkg::MIN_IHL;
    pseudo   = (proto_q == ipv4cs_pkg::PROTO_TCP) || (proto_q == ipv4cs_pkg::PROTO_UDP);
    cpos_hit = ipv4cs_pkg::has_field(proto_q) && (hp == ipv4cs_pkg::pos_t'(cpos));

    in_transport = ihl_ok && (hp >= ipv4cs_pkg::pos_t'(tstart))
                   && (ipv4cs_pkg::pos_ext_t'(pos_q) < tend);
    even_tail    = ihl_ok && (pos_q >= ipv4cs_pkg::pos_t'(tstart)) && (pos_p1 == tend);

    ipv4_n    = ipv4_q;
    ihl_n     = ihl_q;
    tot_n     = tot_q;
    proto_n   = proto_q;
    pend_n    = pend_q;
    hsum_n    = hsum_q;
    udp_old_n = udp_old_q;
    psum_en   = 1'b0;
    psum_add  = word;

    if (pos_q == ipv4cs_pkg::POS_ETYPE_HI) begin
      ipv4_n = in_byte_q == ipv4cs_pkg::ETYPE_HI;
    end
    if (pos_q == ipv4cs_pkg::POS_ETYPE_LO && in_byte_q != ipv4cs_pkg::ETYPE_LO) begin
      ipv4_n = 1'b0;
    end
    if (pos_q == ipv4cs_pkg::POS_VER_IHL) begin
      ihl_n = {1'b0, in_byte_q[3:0], 2'b00};
    end
    if (pos_q == ipv4cs_pkg::POS_TOT_HI) begin
      tot_n = {in_byte_q, 8'd0};
    end
    if (pos_q == ipv4cs_pkg::POS_TOT_LO) begin
      tot_n = {tot_q[15:8], in_byte_q};
    end
    if (pos_q == ipv4cs_pkg::POS_PROTO) begin
      proto_n = in_byte_q;
    end

    if (!pos_q[0]) begin
      pend_n = in_byte_q;
      if (even_tail) begin
        psum_en  = 1'b1;
        psum_add = {in_byte_q, 8'd0};
      end
    end else if (pos_q >= ipv4cs_pkg::POS_FIRST_HW) begin
      if (ipv4cs_pkg::pos_ext_t'(pos_q) < ipv4cs_pkg::pos_ext_t'(tstart)
          && hp != ipv4cs_pkg::POS_HCSUM) begin
        hsum_n = ipv4cs_pkg::ones_add(hsum_q, word);
      end
      if (pseudo && hp >= ipv4cs_pkg::POS_SRC_ADDR && hp <= ipv4cs_pkg::POS_DST_LAST) begin
        psum_en = 1'b1;
      end
      if (in_transport) begin
        if (proto_q == ipv4cs_pkg::PROTO_UDP && cpos_hit) begin
          udp_old_n = word;
        end
        if (!cpos_hit) begin
          psum_en = 1'b1;
        end
      end
    end

    psum_n = psum_en ? ipv4cs_pkg::ones_add(psum_q, psum_add) : psum_q;

    if (in_last_q) begin
      pos_d     = '0;
      hsum_d    = '0;
      psum_d    = '0;
      ihl_d     = '0;
      tot_d     = '0;
      proto_d   = '0;
      udp_old_d = '0;
      pend_d    = '0;
      ipv4_d    = 1'b0;
    end else begin
      pos_d     = (pos_q == ipv4cs_pkg::POS_MAX) ? pos_q : pos_q + ipv4cs_pkg::pos_t'(1);
      hsum_d    = hsum_n;
      psum_d    = psum_n;
      ihl_d     = ihl_n;
      tot_d     = tot_n;
      proto_d   = proto_n;
      udp_old_d = udp_old_n;
      pend_d    = pend_n;
      ipv4_d    = ipv4_n;
    end
  end

  // Result computation from the snapshot.
  ipv4cs_pkg::fill_status_e status;
  logic [15:0] plen, hc, tc, tfold;
  logic [6:0]  toff;
  logic [17:0] tsum;
  logic [16:0] tfold1;
  logic [7:0]  proto_const;
  logic        frame_ok;

  always_comb begin
    frame_ok = snap_len_q >= ipv4cs_pkg::pos_ext_t'(ipv4cs_pkg::MIN_FRAME)
               && snap_ipv4_q
               && snap_ihl_q >= ipv4cs_pkg::MIN_IHL
               && snap_len_q >= ipv4cs_pkg::pos_ext_t'(snap_tot_q)
                                + ipv4cs_pkg::pos_ext_t'(ipv4cs_pkg::ETH_HDR_LEN)
               && snap_tot_q >= {9'd0, snap_ihl_q};
    plen        = snap_tot_q - {9'd0, snap_ihl_q};
    proto_const = (snap_proto_q == ipv4cs_pkg::PROTO_TCP) ? ipv4cs_pkg::PROTO_TCP
                                                           : ipv4cs_pkg::PROTO_UDP;
    tsum   = {2'd0, snap_psum_q} + {10'd0, proto_const} + {2'd0, plen};
    tfold1 = {1'b0, tsum[15:0]} + {15'd0, tsum[17:16]};
    tfold  = tfold1[15:0] + {15'd0, tfold1[16]};
    toff   = ipv4cs_pkg::ETH_HDR_LEN + snap_ihl_q
             + {2'd0, ipv4cs_pkg::field_offset(snap_proto_q)};

    status = ipv4cs_pkg::STATUS_SKIP;
    hc     = '0;
    tc     = '0;
    if (frame_ok) begin
      status = ipv4cs_pkg::STATUS_HEADER;
      hc     = ~snap_hsum_q;
      case (snap_proto_q)
        ipv4cs_pkg::PROTO_ICMP: begin
          if (plen >= ipv4cs_pkg::MIN_ICMP_UDP) begin
            status = ipv4cs_pkg::STATUS_ICMP;
            tc     = ~snap_psum_q;
          end
        end
        ipv4cs_pkg::PROTO_TCP: begin
          if (plen >= ipv4cs_pkg::MIN_TCP) begin
            status = ipv4cs_pkg::STATUS_TCP;
            tc     = ~tfold;
          end
        end
        ipv4cs_pkg::PROTO_UDP: begin
          if (plen >= ipv4cs_pkg::MIN_ICMP_UDP && snap_udp_old_q != 16'd0) begin
            status = ipv4cs_pkg::STATUS_UDP;
            tc     = (tfold == 16'hFFFF) ? 16'hFFFF : ~tfold;
          end
        end
        default: begin
          status = ipv4cs_pkg::STATUS_HEADER;
        end
      endcase
    end
    if (status == ipv4cs_pkg::STATUS_SKIP || status == ipv4cs_pkg::STATUS_HEADER) begin
      toff = '0;
    end
    out_data_d = {6'd0, toff, tc, hc, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      pos_q        <= '0;
      hsum_q       <= '0;
      psum_q       <= '0;
      ihl_q        <= '0;
      tot_q        <= '0;
      proto_q      <= '0;
      udp_old_q    <= '0;
      pend_q       <= '0;
      ipv4_q       <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (consume) begin
        pos_q     <= pos_d;
        hsum_q    <= hsum_d;
        psum_q    <= psum_d;
        ihl_q     <= ihl_d;
        tot_q     <= tot_d;
        proto_q   <= proto_d;
        udp_old_q <= udp_old_d;
        pend_q    <= pend_d;
        ipv4_q    <= ipv4_d;
      end
      if (snap_ready) begin
        snap_valid_q <= consume && in_last_q;
      end
      if (out_ready) begin
        out_valid_q <= snap_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (snap_ready && consume && in_last_q) begin
      snap_len_q     <= pos_p1;
      snap_ipv4_q    <= ipv4_n;
      snap_ihl_q     <= ihl_n;
      snap_tot_q     <= tot_n;
      snap_proto_q   <= proto_n;
      snap_hsum_q    <= hsum_n;
      snap_psum_q    <= psum_n;
      snap_udp_old_q <= udp_old_n;
    end
    if (out_ready && snap_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_ipv4_checksum_fill_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_checksum_fill_unit: self-checking bench of the checksum fill unit
// Streams Ethernet frames into the unit one byte word at a time and predicts,
// per frame, the status, IPv4 header checksum, transport checksum and field
// offset. A short directed set covers every skip rule, every protocol, short
// transport parts, a zero UDP field, a UDP sum that folds to zero, odd tails
// and trailing bytes. A random set of mostly well-formed frames follows, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------

module tb_ipv4_checksum_fill_unit;

  localparam int WATCHDOG_LIMIT    = 1000;
  localparam int RANDOM_WORDS      = 980;
  localparam int MIN_RANDOM_FRAMES = 12;
  localparam int CALM_WORDS        = 300;

  typedef struct packed {
    ipv4cs_pkg::fill_status_e status;
    logic [15:0]              hdr_csum;
    logic [15:0]              xport_csum;
    logic [6:0]               xport_off;
  } fill_sums_t;

  class checksum_tracker;
    ipv4cs_pkg::pos_t byte_pos;
    logic [16:0] hdr_acc;
    logic [16:0] xport_acc;
    logic [5:0]  hdr_halfwords;
    logic [15:0] ip_total;
    logic [7:0]  ip_proto;
    logic [15:0] udp_field;
    logic [7:0]  hi_byte;
    logic        is_ipv4;
    fill_sums_t  sums_due[$];
    int          errors;
    int          checked;
    int          by_status[5];

    function new();
      clear();
      errors = 0;
      checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void clear();
      byte_pos = '0;
      hdr_acc = '0;
      xport_acc = '0;
      hdr_halfwords = '0;
      ip_total = '0;
      ip_proto = '0;
      udp_field = '0;
      hi_byte = '0;
      is_ipv4 = 1'b0;
    endfunction

    function logic [16:0] fold(int unsigned x);
      x = (x & 32'hFFFF) + (x >> 16);
      x = (x & 32'hFFFF) + (x >> 16);
      return x[16:0];
    endfunction

    function int unsigned csum_field_off();
      case (ip_proto)
        ipv4cs_pkg::PROTO_ICMP: return 2;
        ipv4cs_pkg::PROTO_TCP:  return 16;
        ipv4cs_pkg::PROTO_UDP:  return 6;
        default:                return 32'hFFFFF;
      endcase
    endfunction

    function bit advance(logic [7:0] b, logic last, output fill_sums_t r);
      int unsigned p, ihl, tstart, tend, hp, w, cpos, len, plen;
      bit          pseudo;
      r = '0;
      p = byte_pos;
      ihl = hdr_halfwords * 2;
      tstart = 14 + ihl;
      tend = 14 + ip_total;
      pseudo = (ip_proto == ipv4cs_pkg::PROTO_TCP) || (ip_proto == ipv4cs_pkg::PROTO_UDP);
      if (p == 12) is_ipv4 = (b == ipv4cs_pkg::ETYPE_HI);
      if (p == 13 && b != ipv4cs_pkg::ETYPE_LO) is_ipv4 = 1'b0;
      if (p == 14) begin
        hdr_halfwords = {1'b0, b[3:0], 1'b0};
        ihl = hdr_halfwords * 2;
        tstart = 14 + ihl;
      end
      if (p == 16) ip_total = {b, 8'h00};
      if (p == 17) ip_total[7:0] = b;
      if (p == 23) ip_proto = b;

      if (p[0] == 1'b0) begin
        hi_byte = b;
        if (ihl >= 20 && p >= tstart && p + 1 == tend) xport_acc = fold(xport_acc + {b, 8'h00});
      end else if (p >= 15) begin
        hp = p - 1;
        w = {hi_byte, b};
        if (p < 14 + ihl && hp != 24) hdr_acc = fold(hdr_acc + w);
        if (pseudo && hp >= 26 && hp <= 32) xport_acc = fold(xport_acc + w);
        if (ihl >= 20 && hp >= tstart && p < tend) begin
          cpos = tstart + csum_field_off();
          if (ip_proto == ipv4cs_pkg::PROTO_UDP && hp == cpos) udp_field = w;
          if (hp != cpos) xport_acc = fold(xport_acc + w);
        end
      end

      if (byte_pos != ipv4cs_pkg::POS_MAX) byte_pos = byte_pos + 1'b1;
      if (!last) return 1'b0;

      len = p + 1;
      if (len >= 34 && is_ipv4 && ihl >= 20 && len >= 14 + ip_total && ip_total >= ihl) begin
        plen = ip_total - ihl;
        r.status = ipv4cs_pkg::STATUS_HEADER;
        r.hdr_csum = ~fold(hdr_acc);
        if (ip_proto == ipv4cs_pkg::PROTO_ICMP && plen >= 8) begin
          r.status = ipv4cs_pkg::STATUS_ICMP;
          r.xport_csum = ~fold(xport_acc);
        end else if (ip_proto == ipv4cs_pkg::PROTO_TCP && plen >= 20) begin
          r.status = ipv4cs_pkg::STATUS_TCP;
          r.xport_csum = ~fold(xport_acc + ipv4cs_pkg::PROTO_TCP + plen);
        end else if (ip_proto == ipv4cs_pkg::PROTO_UDP && plen >= 8 && udp_field != 16'h0000) begin
          r.status = ipv4cs_pkg::STATUS_UDP;
          r.xport_csum = ~fold(xport_acc + ipv4cs_pkg::PROTO_UDP + plen);
          if (r.xport_csum == 16'h0000) r.xport_csum = 16'hFFFF;
        end
        if (r.status != ipv4cs_pkg::STATUS_HEADER) begin
          r.xport_off = 7'((tstart + csum_field_off()) & 32'h7F);
        end
      end
      clear();
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      fill_sums_t r;
      if (advance(b, last, r)) sums_due.push_back(r);
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", checked, what);
      errors++;
    endtask

    task match_result(logic [47:0] d);
      fill_sums_t e;
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", d));
        return;
      end
      e = sums_due.pop_front();
      if (d[2:0] !== e.status)
        report_mismatch($sformatf("status got %0d want %0d", d[2:0], e.status));
      if (d[18:3] !== e.hdr_csum)
        report_mismatch($sformatf("header checksum got %h want %h", d[18:3], e.hdr_csum));
      if (d[34:19] !== e.xport_csum)
        report_mismatch($sformatf("transport checksum got %h want %h", d[34:19], e.xport_csum));
      if (d[41:35] !== e.xport_off)
        report_mismatch($sformatf("transport offset got %0d want %0d", d[41:35], e.xport_off));
      if (d[47:42] !== 6'd0)
        report_mismatch($sformatf("pad bits got %h", d[47:42]));
      by_status[e.status]++;
      checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;  // [7:0] frame_byte
  logic        s_axis_tlast_i = 1'b0;   // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;          // [2:0] status, [18:3] header checksum,
                                        // [34:19] transport checksum,
                                        // [41:35] transport offset, [47:42] zero

  checksum_tracker sb = new();
  bit [7:0] frame_bytes[$];
  int  send_gap_pct = 0;
  int  sink_stall_pct = 0;
  bit  calm_tail = 1'b0;
  int  words_sent = 0;
  int  quiet_cycles = 0;

  ipv4_checksum_fill_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) sb.take_byte(s_axis_tdata_i, s_axis_tlast_i);
    if (m_axis_tvalid_o && m_axis_tready_i) sb.match_result(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(99, 0) < sink_stall_pct) begin
        m_axis_tready_i <= 1'b0;
        n = $urandom_range(7, 1);
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic void set_word(int at, bit [15:0] v);
    if (at + 1 < frame_bytes.size()) begin
      frame_bytes[at] = v[15:8];
      frame_bytes[at + 1] = v[7:0];
    end
  endfunction

  function automatic void build_frame(bit [15:0] etype, bit [3:0] ihl, bit [15:0] total,
                                      bit [7:0] proto, int flen);
    frame_bytes.delete();
    for (int i = 0; i < flen; i++) frame_bytes.push_back(8'($urandom));
    set_word(12, etype);
    if (flen > 14) frame_bytes[14] = {4'($urandom), ihl};
    set_word(16, total);
    if (flen > 23) frame_bytes[23] = proto;
  endfunction

  function automatic fill_sums_t forecast_frame();
    checksum_tracker probe;
    fill_sums_t      r;
    probe = new();
    foreach (frame_bytes[i]) begin
      void'(probe.advance(frame_bytes[i], i == frame_bytes.size() - 1, r));
    end
    return r;
  endfunction

  // Rewrites a free payload word so that the UDP sum folds to zero.
  function automatic void force_udp_zero(int ihl_bytes);
    fill_sums_t r;
    set_word(14 + ihl_bytes + 8, 16'h0000);
    r = forecast_frame();
    if (r.status == ipv4cs_pkg::STATUS_UDP) set_word(14 + ihl_bytes + 8, r.xport_csum);
  endfunction

  task automatic send_frame();
    int n;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (!calm_tail && $urandom_range(99, 0) < send_gap_pct) begin
        s_axis_tvalid_i <= 1'b0;
        n = $urandom_range(7, 1);
        repeat (n) @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= frame_bytes[i];
      s_axis_tlast_i <= (i == frame_bytes.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready_o);
      words_sent++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic pick_idling();
    int k;
    k = $urandom_range(2, 0);
    send_gap_pct = (k == 0) ? 0 : (k == 1) ? 10 : 35;
    k = $urandom_range(2, 0);
    sink_stall_pct = (k == 0) ? 0 : (k == 1) ? 12 : 40;
  endtask

  task automatic random_frame();
    int          pick, sub, flen, plen, min_plen, ufield;
    bit [3:0]    ihl;
    bit [7:0]    proto;
    bit [15:0]   total;
    pick = $urandom_range(99, 0);
    if (pick < 70) begin
      sub = $urandom_range(3, 0);
      proto = (sub == 0) ? ipv4cs_pkg::PROTO_ICMP : (sub == 1) ? ipv4cs_pkg::PROTO_TCP :
              (sub == 2) ? ipv4cs_pkg::PROTO_UDP : 8'($urandom);
      ihl = ($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 5)) : 4'd5;
      min_plen = (proto == ipv4cs_pkg::PROTO_TCP) ? 20 :
                 (proto == ipv4cs_pkg::PROTO_ICMP || proto == ipv4cs_pkg::PROTO_UDP) ? 8 : 0;
      if (min_plen > 0 && $urandom_range(99, 0) < 15) plen = $urandom_range(min_plen - 1, 0);
      else plen = min_plen + $urandom_range(30, 0);
      total = 16'(ihl * 4 + plen);
      flen = 14 + total + (($urandom_range(9, 0) < 3) ? $urandom_range(6, 1) : 0);
      build_frame(16'h0800, ihl, total, proto, flen);
      if (proto == ipv4cs_pkg::PROTO_UDP) begin
        ufield = 14 + ihl * 4 + 6;
        if ($urandom_range(99, 0) < 15) set_word(ufield, 16'h0000);
        else if (ufield < frame_bytes.size() && frame_bytes[ufield] == 8'h00)
          frame_bytes[ufield] = 8'h5A;
        if (plen >= 10 && $urandom_range(99, 0) < 10) force_udp_zero(ihl * 4);
      end
    end else if (pick < 85) begin
      sub = $urandom_range(4, 0);
      ihl = 4'd5;
      flen = 14 + 20 + $urandom_range(30, 8);
      total = 16'(flen - 14);
      case (sub)
        0: build_frame(16'h0800 ^ (16'h1 << $urandom_range(15, 0)), ihl, total,
                       ipv4cs_pkg::PROTO_UDP, flen);
        1: build_frame(16'h0800, 4'($urandom_range(4, 0)), total, ipv4cs_pkg::PROTO_TCP, flen);
        2: build_frame(16'h0800, ihl, 16'(total + $urandom_range(20, 1)),
                       ipv4cs_pkg::PROTO_ICMP, flen);
        3: build_frame(16'h0800, ihl, 16'($urandom_range(19, 0)), ipv4cs_pkg::PROTO_UDP, flen);
        default: build_frame(16'h0800, ihl, 16'd20, ipv4cs_pkg::PROTO_ICMP,
                             $urandom_range(33, 14));
      endcase
    end else begin
      frame_bytes.delete();
      flen = $urandom_range(80, 1);
      for (int i = 0; i < flen; i++) frame_bytes.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin : stimulus
    int rand_frames;
    int start_words;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 15;
    sink_stall_pct = 15;
    build_frame(16'h0800, 4'd5, 16'd20, ipv4cs_pkg::PROTO_ICMP, 1);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd19, ipv4cs_pkg::PROTO_ICMP, 33);
    send_frame();
    build_frame(16'h86DD, 4'd5, 16'd40, ipv4cs_pkg::PROTO_TCP, 54);
    send_frame();
    build_frame(16'h0801, 4'd5, 16'd40, ipv4cs_pkg::PROTO_TCP, 54);
    send_frame();
    build_frame(16'h0800, 4'd4, 16'd40, ipv4cs_pkg::PROTO_TCP, 54);
    send_frame();
    build_frame(16'h0800, 4'd0, 16'd40, ipv4cs_pkg::PROTO_UDP, 54);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd41, ipv4cs_pkg::PROTO_TCP, 54);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd19, ipv4cs_pkg::PROTO_ICMP, 40);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd29, ipv4cs_pkg::PROTO_ICMP, 46);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd27, ipv4cs_pkg::PROTO_ICMP, 41);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd40, ipv4cs_pkg::PROTO_TCP, 54);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd39, ipv4cs_pkg::PROTO_TCP, 53);
    send_frame();
    build_frame(16'h0800, 4'd15, 16'd93, ipv4cs_pkg::PROTO_TCP, 107);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd28, ipv4cs_pkg::PROTO_UDP, 42);
    set_word(40, 16'h0000);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd27, ipv4cs_pkg::PROTO_UDP, 41);
    set_word(40, 16'h8001);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd32, ipv4cs_pkg::PROTO_UDP, 46);
    set_word(40, 16'h1234);
    force_udp_zero(20);
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd48, ipv4cs_pkg::PROTO_UDP, 62);
    for (int i = 18; i < 62; i++) frame_bytes[i] = 8'hFF;
    frame_bytes[23] = ipv4cs_pkg::PROTO_UDP;
    send_frame();
    build_frame(16'h0800, 4'd5, 16'd30, 8'h2F, 44);
    send_frame();
    frame_bytes.delete();
    for (int i = 0; i < 40; i++) frame_bytes.push_back(8'h00);
    send_frame();
    drain();

    rand_frames = 0;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS || rand_frames < MIN_RANDOM_FRAMES) begin
      if (words_sent - start_words >= RANDOM_WORDS - CALM_WORDS) calm_tail = 1'b1;
      pick_idling();
      random_frame();
      rand_frames++;
      if (rand_frames % 10 == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d frames over %0d byte words: %0d skipped, %0d header only,",
             sb.checked, words_sent, sb.by_status[ipv4cs_pkg::STATUS_SKIP],
             sb.by_status[ipv4cs_pkg::STATUS_HEADER]);
    $display("%0d with ICMP, %0d with TCP, %0d with UDP checksums; %0d mismatches.",
             sb.by_status[ipv4cs_pkg::STATUS_ICMP], sb.by_status[ipv4cs_pkg::STATUS_TCP],
             sb.by_status[ipv4cs_pkg::STATUS_UDP], sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ipv4cs_pkg.sv
rtl/ipv4_checksum_fill_unit.sv
bench/tb_ipv4_checksum_fill_unit.sv
